// File: hdl/wbss_pkg.sv
// shared constants, register codes and types of the wildcard byte signature scanner
`timescale 1ns / 1ps

package wbss_pkg;

  // default sizes
  localparam int DEF_PATTERN_MAX  = 32;
  localparam int DEF_OFFSET_WIDTH = 32;

  // fixed field widths
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int SIG_BYTES   = 32;
  localparam int WORD_BYTES  = 8;
  localparam int SIG_WORDS   = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int OFFSET_OUT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_LO       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_MID_LO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_MID_HI   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_HI       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD_MASK  = 3'd5;

  // one result item
  typedef struct packed {
    logic                    found;
    logic [OFFSET_OUT_W-1:0] match_offset;
  } res_t;

endpackage

// File: hdl/wbss_if.sv
// item channel interfaces of the scanner: byte input and result output
`timescale 1ns / 1ps

interface wbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbss_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

// File: hdl/wildcard_byte_signature_scan_unit.sv
// Wildcard byte signature scanner, top level.
// Takes one byte per cycle; a byte's result item is registered in the result buffer
// on acceptance and shown at its head. Throughput is one byte per cycle, set by the window
// cell row, which shifts and compares in the same cycle; input stalls only while both
// result buffer entries are held. Synchronous active-low reset restores the register
// defaults and rearms the scan; window bytes are not reset, only compared once filled.
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_unit #(
  parameter int PATTERN_MAX  = wbss_pkg::DEF_PATTERN_MAX,
  parameter int OFFSET_WIDTH = wbss_pkg::DEF_OFFSET_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  wbss_in_if.sink                             in_if,
  wbss_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wbss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LW = wbss_pkg::LEN_W;
  localparam int BW = wbss_pkg::BYTE_W;
  localparam logic [LW:0] PMAX = (LW + 1)'(PATTERN_MAX);

  // configuration registers
  logic [LW-1:0]                   len_cfg_r;
  logic [wbss_pkg::CFG_DATA_W-1:0] pat_r [wbss_pkg::SIG_WORDS];
  logic [wbss_pkg::SIG_BYTES-1:0]  wild_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= LW'(1);
      for (int w = 0; w < wbss_pkg::SIG_WORDS; w++) begin
        pat_r[w] <= '0;
      end
      wild_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbss_pkg::REG_PATTERN_LENGTH: len_cfg_r <= cfg_data[LW-1:0];
        wbss_pkg::REG_BYTES_LO:       pat_r[0]  <= cfg_data;
        wbss_pkg::REG_BYTES_MID_LO:   pat_r[1]  <= cfg_data;
        wbss_pkg::REG_BYTES_MID_HI:   pat_r[2]  <= cfg_data;
        wbss_pkg::REG_BYTES_HI:       pat_r[3]  <= cfg_data;
        wbss_pkg::REG_WILDCARD_MASK:  wild_r    <= cfg_data[wbss_pkg::SIG_BYTES-1:0];
        default: ;
      endcase
    end
  end

  // effective length: zero acts as one, clamp at the window depth
  logic [LW-1:0] len;
  always_comb begin
    if (len_cfg_r == '0) begin
      len = LW'(1);
    end else if ({1'b0, len_cfg_r} > PMAX) begin
      len = PMAX[LW-1:0];
    end else begin
      len = len_cfg_r;
    end
  end

  // signature bytes unpacked from the word registers
  logic [BW-1:0] sig_bytes [wbss_pkg::SIG_BYTES];
  for (genvar j = 0; j < wbss_pkg::SIG_BYTES; j++) begin : g_sig
    assign sig_bytes[j] =
      pat_r[j / wbss_pkg::WORD_BYTES][BW * (j % wbss_pkg::WORD_BYTES) +: BW];
  end

  // scan state
  logic                    reported_r, reported_nxt;
  logic [OFFSET_WIDTH-1:0] seen_r, seen_nxt, seen_inc;
  logic                    in_acc, shift_en, buf_space, push, match;
  logic [PATTERN_MAX-1:0]  cell_hit;
  logic [BW-1:0]           win [PATTERN_MAX];
  wbss_pkg::res_t          res;

  assign in_if.ready = buf_space;
  assign in_acc      = in_if.valid && in_if.ready;
  assign shift_en    = in_acc && !reported_r;

  // row of window cells, newest byte in cell 0
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic [BW-1:0] d_in;
    logic [LW-1:0] k;
    logic          in_use;
    logic [BW-1:0] sig_b;
    logic          wild_b;

    if (i == 0) begin : g_head
      assign d_in = in_if.data_byte;
    end else begin : g_link
      assign d_in = win[i-1];
    end

    // cell i sees the byte that lines up with signature byte len-1-i
    assign k      = len - LW'(i) - LW'(1);
    assign in_use = ((LW + 1)'(i) < {1'b0, len});
    assign sig_b  = k[LW-1] ? '0 : sig_bytes[k[LW-2:0]];
    assign wild_b = k[LW-1] ? 1'b0 : wild_r[k[LW-2:0]];

    wbss_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (d_in),
      .d_q      (win[i]),
      .sig_byte (sig_b),
      .wild     (wild_b),
      .in_use   (in_use),
      .hit      (cell_hit[i])
    );
  end

  // saturating byte count and match decision
  logic [OFFSET_WIDTH-1:0] offset;
  logic [63:0]             offset_wide;

  always_comb begin
    seen_inc    = (seen_r == '1) ? seen_r : seen_r + OFFSET_WIDTH'(1);
    match       = (&cell_hit) && (seen_inc >= OFFSET_WIDTH'(len));
    offset      = seen_inc - OFFSET_WIDTH'(len);
    offset_wide = 64'(offset);
    push        = shift_en && (match || in_if.last_byte);
    res.found        = match;
    res.match_offset = match ? offset_wide[wbss_pkg::OFFSET_OUT_W-1:0] : '0;
  end

  // rearm on the last byte of an image
  always_comb begin
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    if (in_acc) begin
      if (in_if.last_byte) begin
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end else if (!reported_r) begin
        seen_nxt     = seen_inc;
        reported_nxt = match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      reported_r <= reported_nxt;
    end
  end

  // result buffer
  wbss_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (res),
    .space    (buf_space),
    .out_if   (out_if)
  );

endmodule

// File: hdl/wbss_cell.sv
// one window cell: holds a byte, passes it on, compares it with its signature byte
`timescale 1ns / 1ps

module wbss_cell (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [wbss_pkg::BYTE_W-1:0] d_in,
  output logic [wbss_pkg::BYTE_W-1:0] d_q,
  input  logic [wbss_pkg::BYTE_W-1:0] sig_byte,
  input  logic                       wild,
  input  logic                       in_use,
  output logic                       hit
);

  logic [wbss_pkg::BYTE_W-1:0] byte_r;

  // window byte, loaded from the previous cell (cell 0: the input byte) on every shift
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  assign d_q = byte_r;

  // compare the byte this cell takes on the shift
  assign hit = !in_use || wild || (d_in == sig_byte);

endmodule

// File: hdl/wbss_out_buf.sv
// two-entry result buffer between the scan logic and the output channel
`timescale 1ns / 1ps

module wbss_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  wbss_pkg::res_t  push_res,
  output logic            space,
  wbss_out_if.source      out_if
);

  wbss_pkg::res_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign pop   = out_if.valid && out_if.ready;
  assign space = (cnt_r != 2'd2);

  // pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_res;
    end
  end

  // head entry drives the channel
  assign out_if.valid        = (cnt_r != 2'd0);
  assign out_if.found        = entry_r[rd_ptr_r].found;
  assign out_if.match_offset = entry_r[rd_ptr_r].match_offset;

endmodule

// File: hdl/wbss_checker.sv
// port-level checks on the scanner, bound to the top level
`timescale 1ns / 1ps

module wbss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [31:0] out_match_offset
);

  // a waiting result item stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped before it was taken");

  // not-found items carry a zero offset
  a_nf_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_offset == 32'd0)
    else $error("not-found item with nonzero offset");

  // input only stalls while results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // input reopens only after a result was taken
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> $past(out_valid && out_ready))
    else $error("input reopened without a result being taken");

endmodule

bind wildcard_byte_signature_scan_unit wbss_checker u_wbss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_found        (out_if.found),
  .out_match_offset (out_if.match_offset)
);
